[sv/b64d_pkg.sv]
// Shared types, character codes and the alphabet lookup for the base64 stream decoder.
`default_nettype none

package b64d_pkg;

   localparam logic [7:0] CH_PAD = 8'h3D;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_NUL = 8'h00;

   localparam logic [1:0] PHASE_0 = 2'd0;
   localparam logic [1:0] PHASE_1 = 2'd1;
   localparam logic [1:0] PHASE_2 = 2'd2;
   localparam logic [1:0] PHASE_3 = 2'd3;

   localparam logic CMD_DATA     = 1'b0;
   localparam logic CMD_PART_END = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       bad_char;
      logic       part_end;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   // Alphabet character to six-bit value; ok low outside the alphabet.
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      logic [7:0] d;
      s = '0;
      d = '0;
      case (c) inside
         [8'h41:8'h5A]: begin
            d       = c - 8'h41;
            s.ok    = 1'b1;
            s.value = d[5:0];
         end
         [8'h61:8'h7A]: begin
            d       = c - 8'h61 + 8'd26;
            s.ok    = 1'b1;
            s.value = d[5:0];
         end
         [8'h30:8'h39]: begin
            d       = c - 8'h30 + 8'd52;
            s.ok    = 1'b1;
            s.value = d[5:0];
         end
         8'h2B: begin
            s.ok    = 1'b1;
            s.value = 6'd62;
         end
         8'h2F: begin
            s.ok    = 1'b1;
            s.value = 6'd63;
         end
         default: begin
            s.ok    = 1'b0;
            s.value = 6'd0;
         end
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

[sv/b64d_core.sv]
// Decoder state (phase, partial byte, line skip) and the per-beat decode logic.
`default_nettype none

module b64d_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire b64d_pkg::item_type    item,
   output b64d_pkg::result_type       res
);

   logic [1:0] phase_ff, phase_in;
   logic [7:0] partial_ff, partial_in;
   logic       skip_ff, skip_in;
   b64d_pkg::sextet_type sx;

   always_comb begin
      sx         = b64d_pkg::sextet_of(item.data_byte);
      phase_in   = phase_ff;
      partial_in = partial_ff;
      skip_in    = skip_ff;
      res        = '0;
      if (item.cmd == b64d_pkg::CMD_PART_END) begin
         res.part_end = 1'b1;
         if (phase_ff != b64d_pkg::PHASE_0) begin
            res.byte_valid = 1'b1;
            res.out_byte   = partial_ff;
         end
         phase_in   = b64d_pkg::PHASE_0;
         partial_in = '0;
         skip_in    = 1'b0;
      end else if (skip_ff) begin
         if (item.data_byte == b64d_pkg::CH_LF) skip_in = 1'b0;
      end else if (item.data_byte == b64d_pkg::CH_LF) begin
         // bare LF: nothing
      end else if (item.data_byte == b64d_pkg::CH_CR ||
                   item.data_byte == b64d_pkg::CH_NUL) begin
         skip_in = 1'b1;
      end else if (item.data_byte == b64d_pkg::CH_PAD) begin
         phase_in = phase_ff + 2'd1;
      end else if (!sx.ok) begin
         res.bad_char = 1'b1;
      end else begin
         phase_in = phase_ff + 2'd1;
         case (phase_ff)
            b64d_pkg::PHASE_0: begin
               partial_in = {sx.value, 2'b00};
            end
            b64d_pkg::PHASE_1: begin
               res.byte_valid = 1'b1;
               res.out_byte   = partial_ff | {6'd0, sx.value[5:4]};
               partial_in     = {sx.value[3:0], 4'd0};
            end
            b64d_pkg::PHASE_2: begin
               res.byte_valid = 1'b1;
               res.out_byte   = partial_ff | {4'd0, sx.value[5:2]};
               partial_in     = {sx.value[1:0], 6'd0};
            end
            default: begin
               res.byte_valid = 1'b1;
               res.out_byte   = partial_ff | {2'd0, sx.value};
               partial_in     = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= b64d_pkg::PHASE_0;
         partial_ff <= '0;
         skip_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         partial_ff <= partial_in;
         skip_ff    <= skip_in;
      end
   end

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      advance && item.cmd == b64d_pkg::CMD_PART_END |=>
         phase_ff == b64d_pkg::PHASE_0 && partial_ff == 8'd0 && !skip_ff)
      else $error("part end did not clear decoder state");

   a_data_byte_needs_phase: assert property (@(posedge clock) disable iff (reset)
      advance && item.cmd == b64d_pkg::CMD_DATA && res.byte_valid |->
         phase_ff != b64d_pkg::PHASE_0 && !skip_ff)
      else $error("byte emitted from phase zero or while skipping");

   a_skip_holds: assert property (@(posedge clock) disable iff (reset)
      advance && item.cmd == b64d_pkg::CMD_DATA && skip_ff &&
         item.data_byte != b64d_pkg::CH_LF |=> skip_ff)
      else $error("line skip ended before LF");

   a_quantum_end_clears: assert property (@(posedge clock) disable iff (reset)
      advance && item.cmd == b64d_pkg::CMD_DATA && res.byte_valid &&
         phase_ff == b64d_pkg::PHASE_3 |=> partial_ff == 8'd0 && phase_ff == b64d_pkg::PHASE_0)
      else $error("partial byte not cleared after fourth sextet");

endmodule

`default_nettype wire

[sv/base64_stream_decoder_top.sv]
// Top level of the base64 stream decoder: input register, decode core, result register.
// Path: an accepted beat is held in the input register, then passes through the core into the result register on rsp_*.
// Throughput: one beat per cycle while rsp_stall is low; the input register refills while a result waits.
// Every input beat yields exactly one result beat.
// Reset (synchronous, active high) empties both registers and clears phase,
// partial byte and line-skip state.
`default_nettype none

module base64_stream_decoder_top (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_cmd,
   input  wire logic [7:0] req_data_byte,
   // response channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_byte_valid,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_bad_char,
   output logic            rsp_part_end
);

   // Stage 1: registered request beat.
   logic                 in_valid_ff, in_valid_in;
   b64d_pkg::item_type   in_item_ff;
   // Stage 2: registered result beat.
   logic                 out_valid_ff, out_valid_in;
   b64d_pkg::result_type out_res_ff;
   b64d_pkg::result_type core_res;

   logic out_free;   // result register can take a new beat this cycle
   logic advance;    // stage 1 beat moves through the core into stage 2
   logic req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   // Stall only when stage 1 is full and cannot drain.
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance  || (out_valid_ff && rsp_stall);

   b64d_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .res     (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.cmd       <= req_cmd;
         in_item_ff.data_byte <= req_data_byte;
      end
      if (advance) begin
         out_res_ff <= core_res;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_byte_valid = out_res_ff.byte_valid;
   assign rsp_out_byte   = out_res_ff.out_byte;
   assign rsp_bad_char   = out_res_ff.bad_char;
   assign rsp_part_end   = out_res_ff.part_end;

   a_no_drop_on_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff && $stable(out_res_ff))
      else $error("result beat lost or changed under stall");

   a_stage1_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("pending request beat overwritten");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("request stalled with room in the pipeline");

endmodule

`default_nettype wire
